// File: src/kqkd_pkg.sv
package kqkd_pkg;

    // operation codes carried with each beat
    typedef enum logic [1:0] {
        KIND_ENC    = 2'd0,
        KIND_DEC    = 2'd1,
        KIND_DERIVE = 2'd2
    } kind_t;

    localparam logic [31:0] NLF_TABLE   = 32'h3A5C742E;
    localparam logic [31:0] DERIVE_HIGH = 32'h60000000;
    localparam logic [31:0] DERIVE_LOW  = 32'h20000000;
    localparam int          KEY_BITS    = 64;

    // one item in flight: operation and the two cipher lanes
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] lane_hi;
        logic [31:0] lane_lo;
    } item_t;

    // nonlinear function lookup
    function automatic logic nlf(input logic [4:0] sel);
        nlf = NLF_TABLE[sel];
    endfunction

    // one forward round, new bit enters at the top
    function automatic logic [31:0] enc_round(input logic [31:0] x, input logic kbit);
        logic fb;
        fb = x[0] ^ x[16] ^ kbit ^ nlf({x[31], x[26], x[20], x[9], x[1]});
        enc_round = {fb, x[31:1]};
    endfunction

    // one inverse round, new bit enters at the bottom
    function automatic logic [31:0] dec_round(input logic [31:0] x, input logic kbit);
        logic fb;
        fb = x[31] ^ x[15] ^ kbit ^ nlf({x[30], x[25], x[19], x[8], x[0]});
        dec_round = {x[30:0], fb};
    endfunction

    // result word from a finished item
    function automatic logic [63:0] make_result(input item_t it);
        logic [63:0] res;
        case (it.kind) inside
            KIND_ENC, KIND_DEC: res = {32'd0, it.lane_hi};
            KIND_DERIVE:        res = {it.lane_hi, it.lane_lo};
            default:            res = 64'd0;
        endcase
        make_result = res;
    endfunction

endpackage

// File: src/kqkd_stage.sv
module kqkd_stage #(
    parameter int FIRST_ROUND = 0,
    parameter int NUM_ROUNDS  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  kqkd_pkg::item_t     in_item,
    input  logic [63:0]         key,
    output logic                out_valid,
    output kqkd_pkg::item_t     out_item
);
    import kqkd_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // unrolled rounds of this stage on both lanes
    always_comb
    begin
        item_next = in_item;
        for (int j = 0; j < NUM_ROUNDS; j++)
        begin
            if (in_item.kind == KIND_ENC)
            begin
                item_next.lane_hi = enc_round(item_next.lane_hi,
                                              key[6'((FIRST_ROUND + j) & (KEY_BITS - 1))]);
                item_next.lane_lo = enc_round(item_next.lane_lo,
                                              key[6'((FIRST_ROUND + j) & (KEY_BITS - 1))]);
            end
            else
            begin
                item_next.lane_hi = dec_round(item_next.lane_hi,
                                              key[6'((15 - FIRST_ROUND - j) & (KEY_BITS - 1))]);
                item_next.lane_lo = dec_round(item_next.lane_lo,
                                              key[6'((15 - FIRST_ROUND - j) & (KEY_BITS - 1))]);
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: src/kqkd_out.sv
module kqkd_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pipe_valid,
    input  kqkd_pkg::item_t     pipe_item,
    output logic                pipe_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [63:0]         result_word
);
    import kqkd_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic [63:0] skid_data_reg;
    logic [63:0] skid_data_next;
    logic        beat;
    logic [63:0] beat_data;

    assign pipe_ready = !skid_valid_reg;
    assign beat       = pipe_valid && pipe_ready;
    assign beat_data  = make_result(pipe_item);

    // output register with a one-entry skid behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && out_stall)
        begin
            if (beat)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = beat_data;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = beat;
            out_data_next  = beat_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_word = out_data_reg;

endmodule

// File: src/keeloq_cipher_with_key_derivation_top.sv
// each beat passes the input stage, the round stages and the result register in order
// throughput: one beat per cycle while in_stall is low; each round stage holds up to RPS unrolled rounds on two lanes
// a stalled output takes one more beat into the skid entry, then input stall is raised
// reset clears all valid bits and the key register; payload registers are not reset
// key writes are taken at any time and must only happen with the pipeline empty
module keeloq_cipher_with_key_derivation_top #(
    parameter int ROUNDS = 528,
    parameter int RPS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cipher_key,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_word
);
    import kqkd_pkg::*;

    localparam int NumStages = (ROUNDS + RPS - 1) / RPS;

    logic [63:0]        key_reg;
    logic               pipe_ready;
    logic [NumStages:0] chain_valid;
    item_t              chain_item [NumStages+1];
    logic               prep_valid_reg;
    item_t              prep_item_reg;
    item_t              prep_item_next;

    // key register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cipher_key;
        end
    end

    // input stage: load lanes, derive adds the serial offsets
    assign in_stall = !pipe_ready;

    always_comb
    begin
        prep_item_next.kind = kind;
        unique case (kind)
            KIND_DERIVE:
            begin
                prep_item_next.lane_hi = data_word + DERIVE_HIGH;
                prep_item_next.lane_lo = data_word + DERIVE_LOW;
            end
            default:
            begin
                prep_item_next.lane_hi = data_word;
                prep_item_next.lane_lo = data_word;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (pipe_ready)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_ready)
        begin
            prep_item_reg <= prep_item_next;
        end
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_item[0]  = prep_item_reg;

    // round stages
    for (genvar s = 0; s < NumStages; s++)
    begin : g_stage
        localparam int First = s * RPS;
        localparam int Count = (ROUNDS - First < RPS) ? (ROUNDS - First) : RPS;

        kqkd_stage #(
            .FIRST_ROUND (First),
            .NUM_ROUNDS  (Count)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_ready),
            .in_valid  (chain_valid[s]),
            .in_item   (chain_item[s]),
            .key       (key_reg),
            .out_valid (chain_valid[s+1]),
            .out_item  (chain_item[s+1])
        );
    end

    // result register and skid
    kqkd_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .pipe_valid  (chain_valid[NumStages]),
        .pipe_item   (chain_item[NumStages]),
        .pipe_ready  (pipe_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word)
    );

    // accepted beat lands in the input stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> chain_valid[0])
        else $error("accepted beat missing from input stage");

    // skid full implies a result is on show
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid full with no output valid");

    // a frozen pipeline keeps every valid bit
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_ready |=> $stable(chain_valid))
        else $error("pipeline moved while frozen");

    // input stall only rises after a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall raised without output stall");

endmodule
